@@ src/tjrf_pkg.sv @@
// Shared types and constants for the touch jump rejection filter.
package tjrf_pkg;

    localparam int unsigned LIMIT_W    = 13;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JUMP_LIMIT  = 2'd0,
        CFG_AGREE_LIMIT = 2'd1,
        CFG_AGREE_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        REQ_PRESS = 1'b0,
        REQ_MOVE  = 1'b1
    } t_req_type;

    localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RST  = 13'd30;
    localparam logic [LIMIT_W-1:0] AGREE_LIMIT_RST = 13'd12;
    localparam logic [COUNT_W-1:0] AGREE_COUNT_RST = 4'd3;

endpackage

@@ src/tjrf_if.sv @@
// Valid/ready channel interfaces for touch sample requests and filtered results.
interface tjrf_in_if #(
    parameter int unsigned COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [COORD_BITS-1:0] sample_x;
    logic [COORD_BITS-1:0] sample_y;

    modport source (output valid, output req_type, output sample_x, output sample_y,
                    input ready);
    modport sink   (input valid, input req_type, input sample_x, input sample_y,
                    output ready);
endinterface

interface tjrf_out_if #(
    parameter int unsigned COORD_BITS = 12
);
    logic                                valid;
    logic                                ready;
    logic [COORD_BITS-1:0]               pos_x;
    logic [COORD_BITS-1:0]               pos_y;
    logic [tjrf_pkg::COUNT_W-1:0]        jump_run;

    modport source (output valid, output pos_x, output pos_y, output jump_run,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input jump_run,
                    output ready);
endinterface

@@ src/touch_jump_rejection_filter_unit.sv @@
// Touch jump rejection filter: request register, one-pass filter logic, result register.
// An accepted request is held in the request register, then moves into the result register.
// Throughput: one request per cycle unless the result stalls; the filter state updates
//   in the cycle the request moves from the request register into the result register.
// A stalled result holds the request register; a new request enters as the old one moves.
// Reset (synchronous, active low): held position and run count clear to zero,
//   thresholds return to 30 / 12 / 3, both pipeline registers empty.
module touch_jump_rejection_filter_unit #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tjrf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tjrf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tjrf_in_if.sink                           i_in,
    tjrf_out_if.source                        o_out
);

    // Compare width: covers both a Manhattan distance and a 13-bit threshold.
    localparam int unsigned DIST_W = COORD_BITS + 1;
    localparam int unsigned CMP_W  = (DIST_W > tjrf_pkg::LIMIT_W) ? DIST_W
                                                                  : tjrf_pkg::LIMIT_W;
    localparam int unsigned CW     = tjrf_pkg::COUNT_W;

    // Threshold registers
    logic [tjrf_pkg::LIMIT_W-1:0] r_jump_limit;
    logic [tjrf_pkg::LIMIT_W-1:0] r_agree_limit;
    logic [CW-1:0]                r_agree_count;

    // Request register
    logic                  r_in_valid;
    logic                  r_in_req;
    logic [COORD_BITS-1:0] r_in_x;
    logic [COORD_BITS-1:0] r_in_y;

    // Filter state
    logic [COORD_BITS-1:0] r_held_x, n_held_x;
    logic [COORD_BITS-1:0] r_held_y, n_held_y;
    logic [COORD_BITS-1:0] r_cand_x, n_cand_x;
    logic [COORD_BITS-1:0] r_cand_y, n_cand_y;
    logic [CW-1:0]         r_run,    n_run;

    // Result register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic [CW-1:0]         r_out_run;

    logic                  out_free;
    logic                  adv;

    logic [COORD_BITS-1:0] dhx, dhy, dcx, dcy;
    logic [DIST_W-1:0]     dist_held, dist_cand;
    logic                  is_slide, is_agree;
    logic [CW:0]           run_inc;

    // ---------------------------------------------------------------
    // Handshake: the result register frees when empty or being taken;
    // the request advances whenever it has somewhere to go.
    // ---------------------------------------------------------------
    assign out_free   = !r_out_valid || o_out.ready;
    assign adv        = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    // ---------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit  <= tjrf_pkg::JUMP_LIMIT_RST;
            r_agree_limit <= tjrf_pkg::AGREE_LIMIT_RST;
            r_agree_count <= tjrf_pkg::AGREE_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tjrf_pkg::CFG_JUMP_LIMIT:  r_jump_limit  <= i_cfg_data;
                tjrf_pkg::CFG_AGREE_LIMIT: r_agree_limit <= i_cfg_data;
                tjrf_pkg::CFG_AGREE_COUNT: r_agree_count <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Request register: load on acceptance, empty when advanced.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_req <= i_in.req_type;
            r_in_x   <= i_in.sample_x;
            r_in_y   <= i_in.sample_y;
        end
    end

    // ---------------------------------------------------------------
    // Distances: sample to held position, sample to last jump candidate.
    // ---------------------------------------------------------------
    always_comb begin
        dhx = (r_in_x >= r_held_x) ? r_in_x - r_held_x : r_held_x - r_in_x;
        dhy = (r_in_y >= r_held_y) ? r_in_y - r_held_y : r_held_y - r_in_y;
        dcx = (r_in_x >= r_cand_x) ? r_in_x - r_cand_x : r_cand_x - r_in_x;
        dcy = (r_in_y >= r_cand_y) ? r_in_y - r_cand_y : r_cand_y - r_in_y;
        dist_held = DIST_W'(dhx) + DIST_W'(dhy);
        dist_cand = DIST_W'(dcx) + DIST_W'(dcy);
        is_slide  = CMP_W'(dist_held) <= CMP_W'(r_jump_limit);
        // The candidate is only meaningful while a run is pending.
        is_agree  = (r_run != '0) && (CMP_W'(dist_cand) <= CMP_W'(r_agree_limit));
        run_inc   = {1'b0, r_run} + (CW+1)'(1);
    end

    // ---------------------------------------------------------------
    // Filter decision
    // ---------------------------------------------------------------
    always_comb begin
        n_held_x = r_held_x;
        n_held_y = r_held_y;
        n_cand_x = r_cand_x;
        n_cand_y = r_cand_y;
        n_run    = r_run;
        if (r_in_req == tjrf_pkg::REQ_PRESS || is_slide) begin
            // Press or ordinary slide: take the sample, drop any run.
            n_held_x = r_in_x;
            n_held_y = r_in_y;
            n_run    = '0;
        end else if (is_agree) begin
            // Jump agreeing with the candidate: extend the run, commit when long enough.
            n_cand_x = r_in_x;
            n_cand_y = r_in_y;
            if (run_inc >= {1'b0, r_agree_count}) begin
                n_held_x = r_in_x;
                n_held_y = r_in_y;
                n_run    = '0;
            end else begin
                n_run    = run_inc[CW-1:0];
            end
        end else begin
            // Fresh jump: becomes the new candidate.
            n_cand_x = r_in_x;
            n_cand_y = r_in_y;
            n_run    = CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
            r_run    <= '0;
        end else if (adv) begin
            r_held_x <= n_held_x;
            r_held_y <= n_held_y;
            r_run    <= n_run;
        end
    end

    // Candidate has no reset: it is read only while a run is pending.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cand_x <= n_cand_x;
            r_cand_y <= n_cand_y;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_x   <= n_held_x;
            r_out_y   <= n_held_y;
            r_out_run <= n_run;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.pos_x    = r_out_x;
    assign o_out.pos_y    = r_out_y;
    assign o_out.jump_run = r_out_run;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("advanced request did not reach the result register");

    a_no_adv_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !adv)
        else $error("request advanced over a stalled result");

    a_req_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("pending request lost");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && adv) |=> (r_out_run == r_run && r_out_x == r_held_x
                              && r_out_y == r_held_y))
        else $error("result differs from updated filter state");

    a_press_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && adv && r_in_req == tjrf_pkg::REQ_PRESS)
            |=> (r_run == '0 && r_held_x == $past(r_in_x) && r_held_y == $past(r_in_y)))
        else $error("press did not set the held position");

endmodule

@@ dv/tb_touch_jump_rejection_filter_unit.sv @@
// Self-checking testbench for the touch jump rejection filter unit.
`timescale 1ns / 100ps

module tb_touch_jump_rejection_filter_unit;

    localparam int COORD_BITS     = 12;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int STEP_MAX       = 2 * COORD_MAX;
    localparam int HOLD_OFF_LEN   = 120;
    localparam int DRAIN_CYCLES   = 6;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int STEADY_ITEMS   = 25;
    localparam int CFG_W          = tjrf_pkg::CFG_DATA_W;

    // Index that maps to no register; writes to it must be dropped.
    localparam logic [tjrf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0]        pos_x;
        logic [COORD_BITS-1:0]        pos_y;
        logic [tjrf_pkg::COUNT_W-1:0] jump_run;
    } t_filter_result;

    typedef struct {
        int jump_lim;
        int agree_lim;
        int agree_len;
        int items;
    } t_phase;

    // Held-position tracker: mirrors the filter state and queues the position
    // report that every accepted touch request must produce.
    class t_filter_scoreboard;
        logic [COORD_BITS-1:0]        held_x, held_y;
        logic [COORD_BITS-1:0]        cand_x, cand_y;
        logic [tjrf_pkg::COUNT_W-1:0] run_len;
        logic [tjrf_pkg::LIMIT_W-1:0] jump_lim;
        logic [tjrf_pkg::LIMIT_W-1:0] agree_lim;
        logic [tjrf_pkg::COUNT_W-1:0] agree_len;
        t_filter_result               position_q[$];
        int                           errors;
        int                           checked;

        function new();
            held_x    = '0;
            held_y    = '0;
            cand_x    = '0;
            cand_y    = '0;
            run_len   = '0;
            jump_lim  = tjrf_pkg::JUMP_LIMIT_RST;
            agree_lim = tjrf_pkg::AGREE_LIMIT_RST;
            agree_len = tjrf_pkg::AGREE_COUNT_RST;
            errors    = 0;
            checked   = 0;
        endfunction

        function int taxicab(int ax, int ay, int bx, int by);
            int dx, dy;
            dx = (ax >= bx) ? ax - bx : bx - ax;
            dy = (ay >= by) ? ay - by : by - ay;
            return dx + dy;
        endfunction

        function void write_reg(logic [tjrf_pkg::CFG_IDX_W-1:0] idx,
                                logic [tjrf_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tjrf_pkg::CFG_JUMP_LIMIT:  jump_lim  = data[tjrf_pkg::LIMIT_W-1:0];
                tjrf_pkg::CFG_AGREE_LIMIT: agree_lim = data[tjrf_pkg::LIMIT_W-1:0];
                tjrf_pkg::CFG_AGREE_COUNT: agree_len = data[tjrf_pkg::COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(tjrf_pkg::t_req_type kind, logic [COORD_BITS-1:0] sx,
                                   logic [COORD_BITS-1:0] sy);
            int             step;
            int             next_len;
            t_filter_result res;
            step = taxicab(int'(sx), int'(sy), int'(held_x), int'(held_y));
            if (kind == tjrf_pkg::REQ_PRESS || step <= int'(jump_lim)) begin
                held_x  = sx;
                held_y  = sy;
                run_len = '0;
            end else if (run_len != 0 &&
                         taxicab(int'(sx), int'(sy), int'(cand_x), int'(cand_y))
                             <= int'(agree_lim)) begin
                cand_x   = sx;
                cand_y   = sy;
                next_len = int'(run_len) + 1;
                if (next_len >= int'(agree_len)) begin
                    held_x  = cand_x;
                    held_y  = cand_y;
                    run_len = '0;
                end else begin
                    run_len = next_len[tjrf_pkg::COUNT_W-1:0];
                end
            end else begin
                cand_x  = sx;
                cand_y  = sy;
                run_len = 1;
            end
            res.pos_x    = held_x;
            res.pos_y    = held_y;
            res.jump_run = run_len;
            position_q.push_back(res);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_filter_result got);
            t_filter_result want;
            if (position_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual x=%0d y=%0d run=%0d",
                         $time, got.pos_x, got.pos_y, got.jump_run);
                return;
            end
            want = position_q.pop_front();
            checked++;
            compare_field("pos_x", int'(want.pos_x), int'(got.pos_x));
            compare_field("pos_y", int'(want.pos_y), int'(got.pos_y));
            compare_field("jump_run", int'(want.jump_run), int'(got.jump_run));
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [tjrf_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tjrf_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tjrf_in_if  #(.COORD_BITS(COORD_BITS)) req_if ();
    tjrf_out_if #(.COORD_BITS(COORD_BITS)) res_if ();

    touch_jump_rejection_filter_unit #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if),
        .o_out      (res_if)
    );

    t_filter_scoreboard sb = new();

    int   samples_sent = 0;
    int   cfg_writes   = 0;
    int   input_stalls = 0;
    int   cycle_count  = 0;
    bit   no_idle      = 1'b0;   // both sides run back to back while set
    bit   hold_off_req = 1'b0;   // ask the result side for one long stall

    // Walk through several threshold settings, extremes included. Agree count
    // of zero is out of the documented range but the register accepts it.
    t_phase plan [8] = '{
        '{0,    0,    1,  150},
        '{8190, 8190, 15, 40},
        '{200,  50,   5,  140},
        '{5,    100,  2,  140},
        '{3000, 0,    15, 60},
        '{40,   8190, 15, 60},
        '{30,   12,   3,  150},
        '{60,   20,   0,  50}
    };

    // Clock: 20 ns period.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Give up if the run hangs; a hang also covers a lost result.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check every result handed over, against the oldest queued position.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result({res_if.pos_x, res_if.pos_y, res_if.jump_run});
        if (i_rst_n && req_if.valid && !req_if.ready)
            input_stalls <= input_stalls + 1;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random back-pressure, steady stretches, one long hold-off.
    initial begin : result_sink
        int gap;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                // Hold ready low long enough for the pipeline to fill up.
                res_if.ready <= 1'b0;
                for (int c = 0; c < HOLD_OFF_LEN; c++)
                    @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (no_idle) begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one touch request after a random gap and hold it until accepted.
    // Keep valid high across back-to-back requests.
    task automatic send_sample(tjrf_pkg::t_req_type kind, logic [COORD_BITS-1:0] sx,
                               logic [COORD_BITS-1:0] sy);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.sample_x <= sx;
        req_if.sample_y <= sy;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        sb.note_request(kind, sx, sy);
        samples_sent++;
    endtask

    // Write one register; the enable drops on the following edge.
    task automatic cfg_write(logic [tjrf_pkg::CFG_IDX_W-1:0] idx,
                             logic [tjrf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    // Drop valid, wait for every queued position to come back, then let the
    // pipeline go quiet before touching the registers.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.position_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Step size that favors the exact limit and one past it.
    function automatic int near_limit(int lim);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return lim;
        if (r < 5)
            return lim + 1;
        return $urandom_range(0, lim + lim / 2 + 2);
    endfunction

    // Pick a point at Manhattan distance step from (bx, by), reflecting at the
    // panel edges so the distance holds wherever it can.
    function automatic void step_from(int bx, int by, int step,
                                      output logic [COORD_BITS-1:0] nx,
                                      output logic [COORD_BITS-1:0] ny);
        int dx, dy, px, py;
        if (step > STEP_MAX)
            step = STEP_MAX;
        dx = $urandom_range(0, (step > COORD_MAX) ? COORD_MAX : step);
        dy = step - dx;
        if (dy > COORD_MAX) begin
            dx = dx + dy - COORD_MAX;
            dy = COORD_MAX;
        end
        px = $urandom_range(0, 1) ? bx + dx : bx - dx;
        if (px > COORD_MAX) px = bx - dx;
        if (px < 0)         px = bx + dx;
        if (px > COORD_MAX) px = COORD_MAX;
        py = $urandom_range(0, 1) ? by + dy : by - dy;
        if (py > COORD_MAX) py = by - dy;
        if (py < 0)         py = by + dy;
        if (py > COORD_MAX) py = COORD_MAX;
        nx = px[COORD_BITS-1:0];
        ny = py[COORD_BITS-1:0];
    endfunction

    // Random gestures: a press followed by slides and jump bursts, with some
    // stray requests mixed in.
    task automatic run_gestures(int count);
        int                    goal;
        int                    pick;
        int                    burst;
        int                    step;
        logic [COORD_BITS-1:0] nx, ny;
        goal = samples_sent + count;
        while (samples_sent < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                send_sample(tjrf_pkg::t_req_type'($urandom_range(0, 1)),
                            COORD_BITS'($urandom_range(0, COORD_MAX)),
                            COORD_BITS'($urandom_range(0, COORD_MAX)));
            end else begin
                if ($urandom_range(0, 6) == 0) begin
                    nx = COORD_BITS'($urandom_range(0, 1) ? COORD_MAX : 0);
                    ny = COORD_BITS'($urandom_range(0, 1) ? COORD_MAX : 0);
                end else begin
                    nx = COORD_BITS'($urandom_range(0, COORD_MAX));
                    ny = COORD_BITS'($urandom_range(0, COORD_MAX));
                end
                send_sample(tjrf_pkg::REQ_PRESS, nx, ny);
                repeat ($urandom_range(3, 16)) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        // Slide around the held position, near the jump limit.
                        step_from(int'(sb.held_x), int'(sb.held_y),
                                  near_limit(int'(sb.jump_lim)), nx, ny);
                        send_sample(tjrf_pkg::REQ_MOVE, nx, ny);
                    end else if (pick < 90) begin
                        // Jump away, then trail samples that mostly agree.
                        step = int'(sb.jump_lim) + 1 + (($urandom_range(0, 3) == 0) ?
                               $urandom_range(0, STEP_MAX) : $urandom_range(0, 40));
                        step_from(int'(sb.held_x), int'(sb.held_y), step, nx, ny);
                        send_sample(tjrf_pkg::REQ_MOVE, nx, ny);
                        burst = int'(sb.agree_len) + $urandom_range(0, 2) - 1;
                        if (burst < 1)
                            burst = 1;
                        repeat (burst) begin
                            step_from(int'(nx), int'(ny), near_limit(int'(sb.agree_lim)),
                                      nx, ny);
                            send_sample(tjrf_pkg::REQ_MOVE, nx, ny);
                        end
                    end else begin
                        send_sample(tjrf_pkg::REQ_MOVE,
                                    COORD_BITS'($urandom_range(0, COORD_MAX)),
                                    COORD_BITS'($urandom_range(0, COORD_MAX)));
                    end
                end
            end
        end
    endtask

    // Directed requests at the reset thresholds (30 / 12 / 3) plus the short
    // detours for the agree-count corner cases.
    task automatic run_directed();
        send_sample(tjrf_pkg::REQ_PRESS, 0, 0);
        send_sample(tjrf_pkg::REQ_PRESS, COORD_MAX, COORD_MAX);
        send_sample(tjrf_pkg::REQ_MOVE, 4095, 4065);   // step equal to jump limit: slide
        send_sample(tjrf_pkg::REQ_MOVE, 4095, 4034);   // one past the limit: run of 1
        send_sample(tjrf_pkg::REQ_MOVE, 4095, 4022);   // agrees at the limit: run of 2
        send_sample(tjrf_pkg::REQ_MOVE, 4083, 4022);   // third jump of the run commits
        send_sample(tjrf_pkg::REQ_MOVE, 0, 0);         // jump to the corner
        send_sample(tjrf_pkg::REQ_MOVE, 13, 0);        // one past agree limit: fresh run
        send_sample(tjrf_pkg::REQ_MOVE, 13, 12);       // agrees: run of 2
        send_sample(tjrf_pkg::REQ_PRESS, 2048, 2048);  // press clears the run
        send_sample(tjrf_pkg::REQ_MOVE, 2048, 2048);   // zero step
        send_sample(tjrf_pkg::REQ_MOVE, 0, COORD_MAX);
        send_sample(tjrf_pkg::REQ_MOVE, COORD_MAX, 0); // disagreeing jump: fresh run
        send_sample(tjrf_pkg::REQ_MOVE, COORD_MAX, 0); // agrees exactly: run of 2
        // Lower the agree count under a pending run; upper data bits are junk.
        settle();
        cfg_write(tjrf_pkg::CFG_AGREE_COUNT, 13'h1FF1);
        send_sample(tjrf_pkg::REQ_MOVE, 4090, 5);      // commits at once
        // Agree count of one: a fresh jump starts a run, the next one commits.
        send_sample(tjrf_pkg::REQ_MOVE, 0, COORD_MAX);
        send_sample(tjrf_pkg::REQ_MOVE, 2, 4093);
        // Agree count of zero: any agreeing jump commits.
        settle();
        cfg_write(tjrf_pkg::CFG_AGREE_COUNT, 13'h0000);
        send_sample(tjrf_pkg::REQ_MOVE, COORD_MAX, COORD_MAX);
        send_sample(tjrf_pkg::REQ_MOVE, COORD_MAX, 4090);
        // Drop a write to the unused index, then restore the reset thresholds.
        settle();
        cfg_write(CFG_IDX_SPARE, 13'h0001);
        cfg_write(tjrf_pkg::CFG_JUMP_LIMIT, tjrf_pkg::JUMP_LIMIT_RST);
        cfg_write(tjrf_pkg::CFG_AGREE_LIMIT, tjrf_pkg::AGREE_LIMIT_RST);
        cfg_write(tjrf_pkg::CFG_AGREE_COUNT, CFG_W'(tjrf_pkg::AGREE_COUNT_RST));
        send_sample(tjrf_pkg::REQ_MOVE, 100, 100);
        send_sample(tjrf_pkg::REQ_PRESS, 100, 100);
    endtask

    initial begin : stimulus
        logic [tjrf_pkg::CFG_DATA_W-1:0] count_word;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= tjrf_pkg::CFG_JUMP_LIMIT;
        i_cfg_data      <= '0;
        req_if.valid    <= 1'b0;
        req_if.req_type <= tjrf_pkg::REQ_PRESS;
        req_if.sample_x <= '0;
        req_if.sample_y <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        foreach (plan[p]) begin
            settle();
            cfg_write(tjrf_pkg::CFG_JUMP_LIMIT, CFG_W'(plan[p].jump_lim));
            cfg_write(tjrf_pkg::CFG_AGREE_LIMIT, CFG_W'(plan[p].agree_lim));
            // Fill the bits above the count field with noise; they must be dropped.
            count_word = {9'($urandom_range(0, 511)), 4'(plan[p].agree_len)};
            cfg_write(tjrf_pkg::CFG_AGREE_COUNT, count_word);
            // Open each phase with a stretch of back-to-back traffic; in the
            // third phase stall the result side meanwhile so the input backs up.
            if (p == 2)
                hold_off_req = 1'b1;
            no_idle = 1'b1;
            run_gestures(STEADY_ITEMS);
            no_idle = 1'b0;
            run_gestures(plan[p].items - STEADY_ITEMS);
        end

        settle();
        $display("Sent %0d touch requests over %0d threshold phases, %0d register writes.",
                 samples_sent, $size(plan) + 1, cfg_writes);
        $display("Checked %0d position reports; input stalled for %0d cycles.",
                 sb.checked, input_stalls);
        if (sb.errors == 0 && sb.position_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
